// File: design/mfsu_pkg.sv
package mfsu_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_LIMIT = 2'd2;

  localparam int CFG_DATA_W = 23;
  localparam logic [7:0]  GRID_WIDTH_RST  = 8'd128;
  localparam logic [7:0]  GRID_HEIGHT_RST = 8'd128;
  localparam logic [22:0] FIELD_LIMIT_RST = 23'd655360;

  // Item action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Field accumulator width
  localparam int ACC_W = 32;

  // Q0.16 constants
  localparam logic signed [17:0] K_085  = 18'sd55706;
  localparam logic signed [17:0] K_020  = 18'sd13107;
  localparam logic signed [17:0] K_001  = 18'sd655;
  localparam logic signed [17:0] K_0005 = 18'sd328;
  localparam logic signed [17:0] K_090  = 18'sd58982;
  localparam logic signed [17:0] K_088  = 18'sd57672;
  localparam logic signed [17:0] K_015  = 18'sd9830;

  localparam logic signed [63:0] CHG_DECAY  = 64'sd5243;
  localparam logic signed [63:0] CHG_MOVE   = 64'sd655;
  localparam logic signed [63:0] CHG_FLOOR  = 64'sd1311;
  localparam logic signed [63:0] CHG_LIMIT  = 64'sd327680;

  typedef struct packed {
    logic              action;
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [23:0] charge_in;
    logic signed [23:0] field_x_in;
    logic signed [23:0] field_y_in;
  } item_t;

  typedef struct packed {
    logic signed [19:0] charge_out;
    logic signed [23:0] field_x_out;
    logic signed [23:0] field_y_out;
  } result_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               stored;
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [23:0] charge;
    logic signed [23:0] fx;
    logic signed [23:0] fy;
  } cmd_t;

  // Round to nearest, ties up, dropping 16 fraction bits.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

  // Weight by Manhattan distance of the neighbour.
  function automatic logic [12:0] dist_weight(input logic [2:0] d);
    logic [12:0] w;
    unique case (d)
      3'd1:    w = 13'd5243;
      3'd2:    w = 13'd3277;
      3'd3:    w = 13'd1966;
      3'd4:    w = 13'd983;
      3'd5:    w = 13'd524;
      3'd6:    w = 13'd262;
      default: w = 13'd0;
    endcase
    return w;
  endfunction

endpackage

// File: design/mfsu_front.sv
module mfsu_front
  import mfsu_pkg::*;
#(
  parameter int GRID_W = 128,
  parameter int GRID_H = 128
) (
  input  logic  start,
  input  logic  busy,
  input  item_t item,
  output logic  push,
  output cmd_t  cmd
);

  logic stored;

  assign stored = (int'(item.col) < GRID_W) && (int'(item.row) < GRID_H);

  // Drop loads outside storage; computes always go on.
  assign push = start && !busy && (item.action == ACT_COMPUTE || stored);

  always_comb begin
    cmd.kind   = (item.action == ACT_COMPUTE) ? CMD_COMPUTE : CMD_LOAD;
    cmd.stored = stored;
    cmd.col    = item.col;
    cmd.row    = item.row;
    cmd.charge = item.charge_in;
    cmd.fx     = item.field_x_in;
    cmd.fy     = item.field_y_in;
  end

endmodule

// File: design/mfsu_fifo.sv
module mfsu_fifo
  import mfsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   count;

  assign valid = (count != '0);
  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

// File: design/mfsu_back.sv
module mfsu_back
  import mfsu_pkg::*;
#(
  parameter int GRID_W = 128,
  parameter int GRID_H = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        pop,
  input  logic [7:0]  grid_width,
  input  logic [7:0]  grid_height,
  input  logic [22:0] field_limit,
  output logic        clearing,
  output logic        strobe,
  output result_t     result
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic       nv;
    logic       ctr;
    logic       last;
    logic [2:0] dx;
    logic [2:0] dy;
    logic [2:0] wi;
  } tag_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  cmd_t              cur;
  logic              first;
  logic signed [2:0] dx;
  logic signed [2:0] dy;
  logic signed [2:0] dx_next;
  logic signed [2:0] dy_next;

  // Grid memories
  logic signed [23:0] mem_c [DEPTH];
  logic signed [23:0] mem_x [DEPTH];
  logic signed [23:0] mem_y [DEPTH];
  logic signed [23:0] rd_c;
  logic signed [23:0] rd_x;
  logic signed [23:0] rd_y;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [23:0] wd_c;
  logic signed [23:0] wd_x;
  logic signed [23:0] wd_y;
  logic [AW-1:0]      raddr;

  // Read sequencer
  logic signed [11:0] nx;
  logic signed [11:0] ny;
  logic [11:0]        wlim;
  logic [11:0]        hlim;
  logic               inb;
  logic [AW-1:0]      naddr;
  logic [AW-1:0]      caddr;
  logic [AW-1:0]      cmd_addr;
  logic [2:0]         adx;
  logic [2:0]         ady;
  tag_t               tag_i;

  // Datapath
  tag_t t1, t2, t3, t4, t5, t6, t7;
  logic f1_v, f2_v, f3_v;
  logic signed [23:0]      chg;
  logic signed [40:0]      cprod;
  logic signed [19:0]      cres;
  logic signed [47:0]      p1;
  logic signed [23:0]      fx2, fy2, fx3, fy3;
  logic signed [23:0]      ia;
  logic signed [48:0]      px, py;
  logic signed [26:0]      idx, idy;
  logic                    neg4, neg5, neg6, neg7;
  logic signed [23:0]      vx, vy;
  logic signed [ACC_W-1:0] tsx4, tsy4, twx4, twy4;
  logic signed [ACC_W-1:0] tsx5, tsy5, twx5, twy5;
  logic signed [ACC_W-1:0] tsx6, tsy6, twx6, twy6;
  logic signed [ACC_W-1:0] tsx7, tsy7, twx7, twy7;
  logic signed [23:0]      ax, ay;
  logic signed [23:0]      hx, hy, gx, gy;
  logic signed [ACC_W-1:0] sx, sy, wx, wy;
  logic signed [ACC_W-1:0] msx, msy, mwx, mwy;
  logic signed [23:0]      zx, zy;

  function automatic logic signed [19:0] charge_next(input logic signed [40:0] p);
    logic signed [63:0] c;
    c = rnd16(64'(p));
    if (c > CHG_MOVE || c < -CHG_MOVE) begin
      c = (c < 0) ? c + CHG_DECAY : c - CHG_DECAY;
    end
    if (c < CHG_FLOOR && c > -CHG_FLOOR) begin
      c = '0;
    end
    if (c > CHG_LIMIT) begin
      c = CHG_LIMIT;
    end else if (c < -CHG_LIMIT) begin
      c = -CHG_LIMIT;
    end
    return 20'(c);
  endfunction

  function automatic logic signed [23:0] clamp_lim(input logic signed [63:0] v,
                                                   input logic [22:0] lim);
    logic signed [63:0] l;
    logic signed [63:0] r;
    l = 64'($signed({1'b0, lim}));
    r = v;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end
    return 24'(r);
  endfunction

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && cmd_valid;

  // Neighbour position and bounds
  always_comb begin
    nx   = $signed({5'b0, cur.col}) + 12'(dx);
    ny   = $signed({5'b0, cur.row}) + 12'(dy);
    wlim = (12'(grid_width) < 12'(GRID_W)) ? 12'(grid_width) : 12'(GRID_W);
    hlim = (12'(grid_height) < 12'(GRID_H)) ? 12'(grid_height) : 12'(GRID_H);
    inb  = (nx >= 0) && (nx < $signed(wlim)) && (ny >= 0) && (ny < $signed(hlim));
    naddr    = AW'(int'(ny) * GRID_W + int'(nx));
    caddr    = AW'(int'(cur.row) * GRID_W + int'(cur.col));
    cmd_addr = AW'(int'(cmd.row) * GRID_W + int'(cmd.col));
    adx = dx[2] ? 3'(-dx) : 3'(dx);
    ady = dy[2] ? 3'(-dy) : 3'(dy);
  end

  // Scan order: dx outer, dy inner, skipping the centre.
  always_comb begin
    dx_next = dx;
    dy_next = dy + 3'sd1;
    if (dy == 3'sd3) begin
      dy_next = -3'sd3;
      dx_next = dx + 3'sd1;
    end
    if (dx_next == 3'sd0 && dy_next == 3'sd0) begin
      dy_next = 3'sd1;
    end
  end

  always_comb begin
    tag_i = '0;
    raddr = naddr;
    if (state == ST_READ) begin
      if (first) begin
        tag_i.ctr = 1'b1;
        raddr     = caddr;
      end else begin
        tag_i.nv   = inb;
        tag_i.last = (dx == 3'sd3) && (dy == 3'sd3);
        tag_i.dx   = dx;
        tag_i.dy   = dy;
        tag_i.wi   = adx + ady;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wd_c  = '0;
    wd_x  = '0;
    wd_y  = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_IDLE && cmd_valid && cmd.kind == CMD_LOAD) begin
      we    = 1'b1;
      waddr = cmd_addr;
      wd_c  = cmd.charge;
      wd_x  = cmd.fx;
      wd_y  = cmd.fy;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_c[waddr] <= wd_c;
    end
    rd_c <= mem_c[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wd_x;
    end
    rd_x <= mem_x[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_y[waddr] <= wd_y;
    end
    rd_y <= mem_y[raddr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      first    <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid && cmd.kind == CMD_COMPUTE) begin
            cur   <= cmd;
            first <= 1'b1;
            dx    <= -3'sd3;
            dy    <= -3'sd3;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (first) begin
            first <= 1'b0;
          end else if (dx == 3'sd3 && dy == 3'sd3) begin
            state <= ST_DRAIN;
          end else begin
            dx <= dx_next;
            dy <= dy_next;
          end
        end
        ST_DRAIN: begin
          if (f3_v) begin
            strobe             <= 1'b1;
            result.charge_out  <= cres;
            result.field_x_out <= 24'(rnd16(64'(zx) * 64'(K_015)));
            result.field_y_out <= 24'(rnd16(64'(zy) * 64'(K_015)));
            state              <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Stage valid tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      t1   <= '0;
      t2   <= '0;
      t3   <= '0;
      t4   <= '0;
      t5   <= '0;
      t6   <= '0;
      t7   <= '0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else begin
      t1   <= tag_i;
      t2   <= t1;
      t3   <= t2;
      t4   <= t3;
      t5   <= t4;
      t6   <= t5;
      t7   <= t6;
      f1_v <= t7.last;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  // Neighbour arithmetic
  always_ff @(posedge clk) begin
    // centre word: latch charge, start the charge product, clear sums
    if (t1.ctr) begin
      chg   <= cur.stored ? rd_c : 24'sd0;
      cprod <= (cur.stored ? rd_c : 24'sd0) * K_085;
    end
    p1  <= chg * rd_c;
    fx2 <= rd_x;
    fy2 <= rd_y;

    if (t2.ctr) begin
      cres <= charge_next(cprod);
    end
    ia  <= sat24(rnd16(64'(p1)));
    fx3 <= fx2;
    fy3 <= fy2;

    idx  <= ia * $signed(t3.dx);
    idy  <= ia * $signed(t3.dy);
    neg4 <= ia[23];
    // pair the magnitude of ia with fields of the same word
    px   <= fx3 * (ia[23] ? -25'(ia) : 25'(ia));
    py   <= fy3 * (ia[23] ? -25'(ia) : 25'(ia));

    vx   <= sat24(rnd16(64'(px)));
    vy   <= sat24(rnd16(64'(py)));
    tsx5 <= tsx4;
    tsy5 <= tsy4;
    twx5 <= twx4;
    twy5 <= twy4;
    neg5 <= neg4;

    ax   <= 24'(rnd16(64'(vx) * 64'($signed({1'b0, dist_weight(t5.wi)}))));
    ay   <= 24'(rnd16(64'(vy) * 64'($signed({1'b0, dist_weight(t5.wi)}))));
    tsx6 <= tsx5;
    tsy6 <= tsy5;
    twx6 <= twx5;
    twy6 <= twy5;
    neg6 <= neg5;

    hx   <= 24'((25'(ax) + 25'sd1) >>> 1);
    hy   <= 24'((25'(ay) + 25'sd1) >>> 1);
    gx   <= 24'(rnd16(64'(ax) * 64'(K_020)));
    gy   <= 24'(rnd16(64'(ay) * 64'(K_020)));
    tsx7 <= tsx6;
    tsy7 <= tsy6;
    twx7 <= twx6;
    twy7 <= twy6;
    neg7 <= neg6;

    if (t1.ctr) begin
      sx <= '0;
      sy <= '0;
      wx <= '0;
      wy <= '0;
    end else if (t7.nv) begin
      sx <= sx + (neg7 ? ACC_W'(hx) : -ACC_W'(hx)) + tsx7;
      sy <= sy + (neg7 ? ACC_W'(hy) : -ACC_W'(hy)) + tsy7;
      wx <= wx + (neg7 ? ACC_W'(gx) : -ACC_W'(gx)) + twx7;
      wy <= wy + (neg7 ? ACC_W'(gy) : -ACC_W'(gy)) + twy7;
    end

    msx <= ACC_W'(rnd16(64'(sx) * 64'(K_090)));
    msy <= ACC_W'(rnd16(64'(sy) * 64'(K_090)));
    mwx <= ACC_W'(rnd16(64'(wx) * 64'(K_088)));
    mwy <= ACC_W'(rnd16(64'(wy) * 64'(K_088)));

    zx <= clamp_lim(64'(msx) + 64'(mwx), field_limit);
    zy <= clamp_lim(64'(msy) + 64'(mwy), field_limit);
  end

  // Displacement terms from the stage-4 products
  always_comb begin
    tsx4 = ACC_W'(rnd16(64'(idx) * 64'(K_001)));
    tsy4 = ACC_W'(rnd16(64'(idy) * 64'(K_001)));
    twx4 = ACC_W'(rnd16(64'(idx) * 64'(K_0005)));
    twy4 = ACC_W'(rnd16(64'(idy) * 64'(K_0005)));
  end

endmodule

// File: design/magnetic_field_stencil_update.sv
// Channel   Direction  Handshake                Payload
// item      in         start high, busy low     item_t   (load or compute one cell)
// result    out        strobe, one cycle        result_t (next values of a cell)
// config    in         wr_en, wr_index          wr_data  (grid_width, grid_height,
//                                                         field_limit)
//
// A load word is written to the grid memories as it leaves the queue. A compute
// word makes 49 reads of the single read port of each grid memory (centre, then
// 48 neighbours) and then passes an arithmetic tail before its strobe; the back
// end takes its next word in the same cycle as the strobe.
// After reset a clearing pass zeroes all GRID_W*GRID_H cells, one cell per cycle;
// busy stays high throughout, config writes still land. busy is also high while
// the two-word command queue is full. The receiver cannot stall: each result
// word is shown for exactly one cycle.
module magnetic_field_stencil_update
  import mfsu_pkg::*;
#(
  parameter int GRID_W = 128,
  parameter int GRID_H = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  strobe,
  output result_t               result,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  // Configuration registers
  logic [7:0]  grid_width;
  logic [7:0]  grid_height;
  logic [22:0] field_limit;

  // Front to queue
  logic push;
  cmd_t push_cmd;

  // Queue to back
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  logic clearing;

  // Hold items off during the clearing pass and while the queue is full.
  assign busy = clearing || q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      field_limit <= FIELD_LIMIT_RST;
    end else if (wr_en) begin
      // Indexes past the list are dropped.
      unique case (wr_index)
        REG_GRID_WIDTH:  grid_width  <= wr_data[7:0];
        REG_GRID_HEIGHT: grid_height <= wr_data[7:0];
        REG_FIELD_LIMIT: field_limit <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Classify the word; drop loads that fall outside storage.
  mfsu_front #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_front (
    .start(start),
    .busy (busy),
    .item (item),
    .push (push),
    .cmd  (push_cmd)
  );

  // Short queue so the front can take a word while the back works.
  mfsu_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_cmd),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_cmd)
  );

  // Grid memories, neighbour scan and arithmetic.
  mfsu_back #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (q_cmd),
    .cmd_valid  (q_valid),
    .pop        (q_pop),
    .grid_width (grid_width),
    .grid_height(grid_height),
    .field_limit(field_limit),
    .clearing   (clearing),
    .strobe     (strobe),
    .result     (result)
  );

endmodule
